// ----- sv/access_log_status_byte_tally_unit_defines.svh -----
// assertion macros shared by the access log tally checker
`ifndef ACCESS_LOG_STATUS_BYTE_TALLY_UNIT_DEFINES_SVH
`define ACCESS_LOG_STATUS_BYTE_TALLY_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define ALSBT_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("alsbt check failed");

// next-cycle implication, held off during reset
`define ALSBT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("alsbt check failed");

// what must hold in the cycle after a reset cycle
`define ALSBT_ASSERT_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("alsbt reset check failed");

`endif

// ----- sv/alsbt_pkg.sv -----
// package: types, constants and helper functions of the access log tally
package alsbt_pkg;

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CODE_W     = 10;

   localparam logic CSR_IDX_COUNTED = 1'b0;
   localparam logic CSR_IDX_SUMMED  = 1'b1;

   localparam logic [CODE_W-1:0] COUNTED_RESET = 10'd404;
   localparam logic [CODE_W-1:0] SUMMED_RESET  = 10'd200;

   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_QUOTE = 8'd34;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_MINUS = 8'd45;

   localparam logic [31:0] STATUS_CAP   = 32'h8000_0000;
   localparam logic [31:0] STATUS_MAX   = 32'h7FFF_FFFF;
   localparam logic [31:0] STATUS_DIV10 = 32'd214748364;
   localparam logic [63:0] BYTES_CAP    = 64'h8000_0000_0000_0000;
   localparam logic [63:0] BYTES_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] BYTES_DIV10  = 64'd922337203685477580;
   localparam logic [39:0] COUNT_MAX    = 40'hFF_FFFF_FFFF;

   typedef enum logic [3:0] {
      PH_SEARCH,
      PH_S_WS,
      PH_S_SIGN,
      PH_S_DIG,
      PH_B_WS,
      PH_B_SIGN,
      PH_B_DIG,
      PH_OK,
      PH_FAIL
   } phase_type;

   // one finished line as handed from parser to tally
   typedef struct packed {
      logic        ok;
      logic        s_neg;
      logic [31:0] s_mag;
      logic        b_neg;
      logic [63:0] b_mag;
   } line_rec_type;

   function automatic logic [31:0] status_step(input logic [31:0] mag, input logic [3:0] d);
      logic [35:0] prod;
      prod = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {32'd0, d};
      if (mag > STATUS_DIV10) begin
         return STATUS_CAP;
      end else if (prod > {4'd0, STATUS_CAP}) begin
         return STATUS_CAP;
      end else begin
         return prod[31:0];
      end
   endfunction

   function automatic logic [63:0] bytes_step(input logic [63:0] mag, input logic [3:0] d);
      logic [67:0] prod;
      prod = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {64'd0, d};
      if (mag > BYTES_DIV10) begin
         return BYTES_CAP;
      end else if (prod > {4'd0, BYTES_CAP}) begin
         return BYTES_CAP;
      end else begin
         return prod[63:0];
      end
   endfunction

endpackage

// ----- sv/alsbt_front.sv -----
// front part: per-character scanner that turns a line into a line record
module alsbt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // char_in
   input  logic                req_tlast,   // line_end
   input  logic                q_full,
   output logic                push,
   output alsbt_pkg::line_rec_type push_rec
);
   import alsbt_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        prev_quote_ff, prev_quote_in;
   logic [31:0] s_acc_ff, s_acc_in;
   logic        s_neg_ff, s_neg_in;
   logic [63:0] b_acc_ff, b_acc_in;
   logic        b_neg_ff, b_neg_in;
   logic        accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && req_tlast;

   always_comb begin
      logic [7:0]  c;
      logic        dig;
      logic        spc;
      logic        sgn;
      logic        ok;
      logic [31:0] s_step;
      logic [63:0] b_step;
      c      = req_tdata;
      dig    = (c >= 8'd48) && (c <= 8'd57);
      spc    = (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
      sgn    = (c == CH_PLUS) || (c == CH_MINUS);
      s_step = status_step(s_acc_ff, c[3:0]);
      b_step = bytes_step(b_acc_ff, c[3:0]);

      phase_in      = phase_ff;
      prev_quote_in = prev_quote_ff;
      s_acc_in      = s_acc_ff;
      s_neg_in      = s_neg_ff;
      b_acc_in      = b_acc_ff;
      b_neg_in      = b_neg_ff;

      if (c == CH_NUL) begin
         // nul ends the line text
         phase_in = ((phase_ff == PH_B_DIG) || (phase_ff == PH_OK)) ? PH_OK : PH_FAIL;
      end else begin
         unique case (phase_ff)
            PH_SEARCH: begin
               if (prev_quote_ff && (c == CH_SPACE)) phase_in = PH_S_WS;
               prev_quote_in = (c == CH_QUOTE);
            end
            PH_S_WS: begin
               priority if (spc) begin
                  phase_in = PH_S_WS;
               end else if (sgn) begin
                  s_neg_in = (c == CH_MINUS);
                  phase_in = PH_S_SIGN;
               end else if (dig) begin
                  s_acc_in = s_step;
                  phase_in = PH_S_DIG;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            PH_S_SIGN: begin
               if (dig) begin
                  s_acc_in = s_step;
                  phase_in = PH_S_DIG;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            PH_S_DIG: begin
               priority if (dig) begin
                  s_acc_in = s_step;
               end else if (spc) begin
                  phase_in = PH_B_WS;
               end else if (sgn) begin
                  // second number may follow directly with its sign
                  b_neg_in = (c == CH_MINUS);
                  phase_in = PH_B_SIGN;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            PH_B_WS: begin
               priority if (spc) begin
                  phase_in = PH_B_WS;
               end else if (sgn) begin
                  b_neg_in = (c == CH_MINUS);
                  phase_in = PH_B_SIGN;
               end else if (dig) begin
                  b_acc_in = b_step;
                  phase_in = PH_B_DIG;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            PH_B_SIGN: begin
               if (dig) begin
                  b_acc_in = b_step;
                  phase_in = PH_B_DIG;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            PH_B_DIG: begin
               if (dig) begin
                  b_acc_in = b_step;
               end else begin
                  phase_in = PH_OK;
               end
            end
            default: begin
               // done or failed: rest of line ignored
            end
         endcase
      end

      ok             = (phase_in == PH_B_DIG) || (phase_in == PH_OK);
      push_rec.ok    = ok;
      push_rec.s_neg = ok && s_neg_in;
      push_rec.s_mag = ok ? s_acc_in : 32'd0;
      push_rec.b_neg = ok && b_neg_in;
      push_rec.b_mag = ok ? b_acc_in : 64'd0;

      if (req_tlast) begin
         // line done: per-line state starts over
         phase_in      = PH_SEARCH;
         prev_quote_in = 1'b0;
         s_acc_in      = 32'd0;
         s_neg_in      = 1'b0;
         b_acc_in      = 64'd0;
         b_neg_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SEARCH;
         prev_quote_ff <= 1'b0;
         s_acc_ff      <= 32'd0;
         s_neg_ff      <= 1'b0;
         b_acc_ff      <= 64'd0;
         b_neg_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         prev_quote_ff <= prev_quote_in;
         s_acc_ff      <= s_acc_in;
         s_neg_ff      <= s_neg_in;
         b_acc_ff      <= b_acc_in;
         b_neg_ff      <= b_neg_in;
      end
   end

endmodule

// ----- sv/alsbt_queue.sv -----
// short queue of line records between scanner and tally
module alsbt_queue #(
   parameter int DEPTH = alsbt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  alsbt_pkg::line_rec_type push_rec,
   output logic                    q_full,
   output logic                    q_valid,
   output alsbt_pkg::line_rec_type q_rec,
   input  logic                    pop
);
   import alsbt_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   line_rec_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_full  = (count_ff == CNT_W'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_rec   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_rec;
   end

endmodule

// ----- sv/alsbt_back.sv -----
// back part: result formatting, running totals and output register
module alsbt_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  alsbt_pkg::line_rec_type q_rec,
   output logic                    pop,
   input  logic [alsbt_pkg::CODE_W-1:0] counted_code,
   input  logic [alsbt_pkg::CODE_W-1:0] summed_code,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [199:0]            rsp_tdata,
   output logic                    rsp_tuser
);
   import alsbt_pkg::*;

   logic        valid_ff, valid_in;
   logic [31:0] status_ff, status_in;
   logic [63:0] bytes_ff, bytes_in;
   logic        ok_ff;
   logic [39:0] err_ff, err_in;
   logic [63:0] sum_ff, sum_in;

   assign pop        = q_valid && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {sum_ff, err_ff, bytes_ff, status_ff};
   assign rsp_tuser  = ok_ff;

   always_comb begin
      logic        s_is_neg;
      logic [31:0] s_pos;
      logic [63:0] b_pos;
      logic        count_hit;
      logic        sum_hit;
      s_is_neg  = q_rec.s_neg && (q_rec.s_mag != 32'd0);
      s_pos     = (q_rec.s_mag > STATUS_MAX) ? STATUS_MAX : q_rec.s_mag;
      b_pos     = q_rec.b_mag[63] ? BYTES_MAX : q_rec.b_mag;
      status_in = s_is_neg ? (32'd0 - q_rec.s_mag) : s_pos;
      bytes_in  = q_rec.b_neg ? (64'd0 - q_rec.b_mag) : b_pos;
      count_hit = !s_is_neg && (s_pos == {22'd0, counted_code});
      sum_hit   = !count_hit && !s_is_neg && (s_pos == {22'd0, summed_code});
      err_in    = (count_hit && (err_ff != COUNT_MAX)) ? err_ff + 40'd1 : err_ff;
      // add or subtract the magnitude, same as adding the signed value mod 2^64
      if (sum_hit) begin
         sum_in = q_rec.b_neg ? (sum_ff - q_rec.b_mag) : (sum_ff + b_pos);
      end else begin
         sum_in = sum_ff;
      end
      valid_in = pop ? 1'b1 : (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         err_ff   <= 40'd0;
         sum_ff   <= 64'd0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            err_ff <= err_in;
            sum_ff <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= status_in;
         bytes_ff  <= bytes_in;
         ok_ff     <= q_rec.ok;
      end
   end

endmodule

// ----- sv/access_log_status_byte_tally_unit.sv -----
// top level: access log status and byte tally unit
//
// request channel (req_*): one log character per request in req_tdata,
// req_tlast set on the last character of a line. a scanner looks for the
// first quote followed by a space and reads the status and byte count.
// result channel (rsp_*): one result per line, sent for the request that
// carries req_tlast. rsp_tdata packs line_status, line_bytes, error_count
// and byte_total; rsp_tuser carries parsed_ok.
// csr port: counted_code at address 0, summed_code at address 4, apb
// timing, pready tied high, reads return the register value.
// throughput: one character per cycle while req_tready is high, including
// line ends; the scanner state update is combinational (mul by ten as
// shifts). the edge that takes the last character of a line writes its
// record into the queue; it then moves on to the output register.
// a line record waits in a small queue between the scanner and the tally
// stage; req_tready drops only while that queue is full, which happens
// when rsp_tready stays low for a while.
// reset: synchronous; clears the scanner, queue, totals and output valid
// and loads counted_code 404, summed_code 200. no clearing pass is needed.
module access_log_status_byte_tally_unit #(
   parameter int QUEUE_DEPTH = alsbt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] char_in
   input  logic                            req_tlast,   // line_end
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [31:0] line_status, [95:32] line_bytes, [135:96] error_count,
   // [199:136] byte_total
   output logic [199:0]                    rsp_tdata,
   output logic                            rsp_tuser,   // [0] parsed_ok
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [alsbt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [alsbt_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [alsbt_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import alsbt_pkg::*;

   logic [CODE_W-1:0] counted_ff;
   logic [CODE_W-1:0] summed_ff;
   logic              csr_wr;
   logic              push;
   logic              pop;
   logic              q_full;
   logic              q_valid;
   line_rec_type      push_rec;
   line_rec_type      q_rec;

   // register port: no wait states
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register index is the word address; bit 2 picks between the two codes
   always_comb begin
      unique case (csr_paddr[2])
         CSR_IDX_COUNTED: csr_prdata = {{(CSR_DATA_W-CODE_W){1'b0}}, counted_ff};
         CSR_IDX_SUMMED:  csr_prdata = {{(CSR_DATA_W-CODE_W){1'b0}}, summed_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counted_ff <= COUNTED_RESET;
         summed_ff  <= SUMMED_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == CSR_IDX_COUNTED) counted_ff <= csr_pwdata[CODE_W-1:0];
         if (csr_paddr[2] == CSR_IDX_SUMMED)  summed_ff  <= csr_pwdata[CODE_W-1:0];
      end
   end

   // scanner: one character per cycle unless q_full, one record per line
   alsbt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push),
      .push_rec   (push_rec)
   );

   // decouples scanner from a stalled result channel
   alsbt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .q_full   (q_full),
      .q_valid  (q_valid),
      .q_rec    (q_rec),
      .pop      (pop)
   );

   // tally: signed result values, error count and byte total
   alsbt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_rec        (q_rec),
      .pop          (pop),
      .counted_code (counted_ff),
      .summed_code  (summed_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

// ----- sv/alsbt_checker.sv -----
// port-level checks for the access log tally unit, bound to the top level
`include "access_log_status_byte_tally_unit_defines.svh"

module alsbt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [199:0]                    rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            csr_pready
);

   // a stalled result stays offered
   `ALSBT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // a stalled result keeps its payload
   `ALSBT_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser))

   // a line that failed to parse reports zero status and zero bytes
   `ALSBT_ASSERT_NOW(a_fail_zero, rsp_tvalid && !rsp_tuser, rsp_tdata[95:0] == 96'd0)

   // reset leaves no result pending and the register port ready
   `ALSBT_ASSERT_RESET(a_reset_idle, !rsp_tvalid && csr_pready)

endmodule

bind access_log_status_byte_tally_unit alsbt_checker u_alsbt_checker (.*);

// ----- tb/sv/access_log_status_byte_tally_unit_test.sv -----
// self-checking testbench for the access log status and byte tally unit
module access_log_status_byte_tally_unit_test;
   import alsbt_pkg::*;

   // codes and characters the stimulus and the tally predictor work with
   localparam logic [CSR_ADDR_W-1:0] ADDR_COUNTED = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SUMMED  = 3'd4;
   localparam logic [7:0]  CH_TAB      = 8'd9;
   localparam logic [7:0]  CH_CR       = 8'd13;
   localparam logic [7:0]  CH_ZERO     = 8'd48;
   localparam logic [7:0]  CH_NINE     = 8'd57;
   localparam logic [63:0] STATUS_CEIL = 64'h8000_0000;
   localparam logic [63:0] BYTES_CEIL  = 64'h8000_0000_0000_0000;
   localparam int RX_OPEN    = 0;
   localparam int RX_CHOPPY  = 1;
   localparam int RX_STARVED = 2;

   typedef logic [7:0] byte_q_type[$];

   // one line result as the tally should report it
   typedef struct {
      logic [31:0] status;
      logic [63:0] bytes;
      logic        ok;
      logic [39:0] errs;
      logic [63:0] total;
   } tally_result_type;

   // line scanner and tally predictor plus the store of results still owed
   class tally_board_type;
      logic [9:0]  counted, summed;
      phase_type   scan_phase;
      bit          quote_seen, status_minus, bytes_minus;
      logic [63:0] status_mag, bytes_mag, sum_bytes;
      logic [39:0] err_lines;
      tally_result_type owed_q[$];
      int          failures, lines_seen, lines_parsed;

      function new();
         counted = COUNTED_RESET;
         summed = SUMMED_RESET;
         err_lines = '0;
         sum_bytes = '0;
         failures = 0;
         lines_seen = 0;
         lines_parsed = 0;
         restart_line();
      endfunction

      function void restart_line();
         scan_phase = PH_SEARCH;
         quote_seen = 0;
         status_mag = '0;
         status_minus = 0;
         bytes_mag = '0;
         bytes_minus = 0;
      endfunction

      function bit blank(logic [7:0] c);
         return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
      endfunction

      function bit digit(logic [7:0] c);
         return c >= CH_ZERO && c <= CH_NINE;
      endfunction

      // decimal shift-in with clamp at the magnitude ceiling
      function logic [63:0] push_digit(logic [63:0] mag, logic [7:0] c, logic [63:0] cap);
         logic [63:0] grown;
         if (mag > cap / 64'd10) return cap;
         grown = mag * 64'd10 + 64'(c - CH_ZERO);
         return (grown > cap) ? cap : grown;
      endfunction

      // whitespace skip and optional sign in front of either number
      function phase_type open_number(logic [7:0] c, bit second);
         if (blank(c)) return second ? PH_B_WS : PH_S_WS;
         if (c == CH_PLUS || c == CH_MINUS) begin
            if (second) bytes_minus = (c == CH_MINUS);
            else status_minus = (c == CH_MINUS);
            return second ? PH_B_SIGN : PH_S_SIGN;
         end
         if (digit(c)) begin
            if (second) bytes_mag = push_digit(bytes_mag, c, BYTES_CEIL);
            else status_mag = push_digit(status_mag, c, STATUS_CEIL);
            return second ? PH_B_DIG : PH_S_DIG;
         end
         return PH_FAIL;
      endfunction

      function void scan(logic [7:0] c);
         // a zero byte ends the text of the line
         if (c == CH_NUL) begin
            scan_phase = (scan_phase == PH_B_DIG || scan_phase == PH_OK) ? PH_OK : PH_FAIL;
            return;
         end
         case (scan_phase)
            PH_SEARCH: begin
               if (quote_seen && c == CH_SPACE) scan_phase = PH_S_WS;
               quote_seen = (c == CH_QUOTE);
            end
            PH_S_WS: scan_phase = open_number(c, 0);
            PH_S_SIGN: begin
               if (digit(c)) begin
                  status_mag = push_digit(status_mag, c, STATUS_CEIL);
                  scan_phase = PH_S_DIG;
               end else begin
                  scan_phase = PH_FAIL;
               end
            end
            PH_S_DIG: begin
               if (digit(c)) status_mag = push_digit(status_mag, c, STATUS_CEIL);
               else scan_phase = open_number(c, 1);
            end
            PH_B_WS: scan_phase = open_number(c, 1);
            PH_B_SIGN: begin
               if (digit(c)) begin
                  bytes_mag = push_digit(bytes_mag, c, BYTES_CEIL);
                  scan_phase = PH_B_DIG;
               end else begin
                  scan_phase = PH_FAIL;
               end
            end
            PH_B_DIG: begin
               if (digit(c)) bytes_mag = push_digit(bytes_mag, c, BYTES_CEIL);
               else scan_phase = PH_OK;
            end
            default: ;
         endcase
      endfunction

      // called for every accepted request
      function void note_request(logic [7:0] c, logic is_last);
         tally_result_type r;
         bit          ok, s_neg;
         logic [63:0] s_abs, b_bits;
         scan(c);
         if (!is_last) return;
         ok = (scan_phase == PH_B_DIG || scan_phase == PH_OK);
         s_neg = 0;
         s_abs = '0;
         b_bits = '0;
         r.status = '0;
         if (ok) begin
            // minus zero counts as a plain zero
            s_neg = status_minus && status_mag != 64'd0;
            if (s_neg) begin
               s_abs = status_mag;
               r.status = 32'(64'd0 - status_mag);
            end else begin
               s_abs = (status_mag > STATUS_CEIL - 64'd1) ? STATUS_CEIL - 64'd1 : status_mag;
               r.status = s_abs[31:0];
            end
            if (bytes_minus) b_bits = 64'd0 - bytes_mag;
            else b_bits = (bytes_mag > BYTES_CEIL - 64'd1) ? BYTES_CEIL - 64'd1 : bytes_mag;
         end
         // the counted code wins when both codes match
         if (!s_neg && s_abs == {54'd0, counted}) begin
            if (err_lines != COUNT_MAX) err_lines = err_lines + 40'd1;
         end else if (!s_neg && s_abs == {54'd0, summed}) begin
            sum_bytes = sum_bytes + b_bits;
         end
         r.bytes = b_bits;
         r.ok = ok;
         r.errs = err_lines;
         r.total = sum_bytes;
         owed_q.push_back(r);
         lines_seen++;
         if (ok) lines_parsed++;
         restart_line();
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= 10) $display("%0t mismatch: %s", $realtime, msg);
      endfunction

      function void compare(string what, logic [63:0] want, logic [63:0] got);
         if (want !== got) flag($sformatf("%s expected 0x%h got 0x%h", what, want, got));
      endfunction

      // called for every accepted result
      function void check_result(logic [199:0] d, logic ok_flag);
         tally_result_type want;
         if (owed_q.size() == 0) begin
            flag($sformatf("result 0x%h arrived with no line pending", d));
            return;
         end
         want = owed_q.pop_front();
         compare("line_status", 64'(want.status), 64'(d[31:0]));
         compare("line_bytes", want.bytes, d[95:32]);
         compare("error_count", 64'(want.errs), 64'(d[135:96]));
         compare("byte_total", want.total, d[199:136]);
         compare("parsed_ok", 64'(want.ok), 64'(ok_flag));
      endfunction

      function void set_code(bit second, logic [31:0] v);
         if (second) summed = v[9:0];
         else counted = v[9:0];
      endfunction

      function void check_readback(bit second, logic [31:0] got);
         compare(second ? "summed_code readback" : "counted_code readback",
                 {54'd0, second ? summed : counted}, 64'(got));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] char_in
   logic                  req_tlast;   // line_end
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [31:0] line_status, [95:32] line_bytes, [135:96] error_count,
   // [199:136] byte_total
   logic [199:0]          rsp_tdata;
   logic                  rsp_tuser;   // [0] parsed_ok
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   tally_board_type sb;
   int         burst_left;
   bit         calm;
   int         reqs_taken;
   int         code_settings;

   access_log_status_byte_tally_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // watchdog: far beyond the slowest legal run
   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // both handshakes are sampled at the rising edge, before the block updates
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_request(req_tdata, req_tlast);
            reqs_taken++;
         end
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // result side backpressure: open stretches, choppy stretches and long stalls
   initial begin
      int mode;
      int span;
      rsp_tready = 1'b0;
      forever begin
         mode = $urandom_range(RX_OPEN, RX_STARVED);
         span = $urandom_range(10, 60);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               RX_OPEN:   rsp_tready <= 1'b1;
               RX_CHOPPY: rsp_tready <= ($urandom_range(0, 9) < 7);
               default:   rsp_tready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // drivers: every task starts and ends at a falling edge
   // ---------------------------------------------------------------------

   task automatic idle(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // one request, held until the block takes it
   task automatic send_char(logic [7:0] c, logic is_last);
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // bursts of random length; calm lines run without any gap
   task automatic send_line(byte_q_type q);
      calm = ($urandom_range(0, 5) == 0);
      foreach (q[i]) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!calm) idle($urandom_range(1, 5));
         end
         burst_left--;
         send_char(q[i], i == q.size() - 1);
      end
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_code(addr == ADDR_SUMMED, value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_read(logic [CSR_ADDR_W-1:0] addr);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= addr;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.check_readback(addr == ADDR_SUMMED, csr_prdata);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // wait until every line result is in, then let the pipe drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.owed_q.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // new code pair with junk in the unused upper data bits, then read back
   task automatic apply_codes(logic [9:0] counted, logic [9:0] summed);
      settle();
      csr_write(ADDR_COUNTED, {22'($urandom), counted});
      csr_write(ADDR_SUMMED, {22'($urandom), summed});
      csr_read(ADDR_COUNTED);
      csr_read(ADDR_SUMMED);
      code_settings++;
   endtask

   // ---------------------------------------------------------------------
   // line builders
   // ---------------------------------------------------------------------

   function automatic byte_q_type text(string s);
      byte_q_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   function automatic byte_q_type decimal(logic [63:0] v);
      byte_q_type q;
      if (v == 64'd0) q.push_back(CH_ZERO);
      while (v != 64'd0) begin
         q.push_front(CH_ZERO + 8'(v % 64'd10));
         v = v / 64'd10;
      end
      return q;
   endfunction

   function automatic byte_q_type long_digits(int n);
      byte_q_type q;
      q.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
      repeat (n - 1) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      return q;
   endfunction

   function automatic logic [7:0] blank_char();
      return $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13));
   endfunction

   // printable, never a quote
   function automatic logic [7:0] text_char();
      logic [7:0] c;
      c = 8'($urandom_range(33, 126));
      return (c == CH_QUOTE) ? 8'd65 : c;
   endfunction

   function automatic byte_q_type pick_status(logic [9:0] counted, logic [9:0] summed);
      byte_q_type q;
      int    sel;
      sel = $urandom_range(0, 19);
      if (sel < 8) q = decimal(64'(counted));
      else if (sel < 13) q = decimal(64'(summed));
      else if (sel < 17) q = decimal(64'($urandom_range(0, 999)));
      else if (sel < 19) q = decimal(64'h7FFF_FFFF + 64'($urandom_range(0, 2)));
      else q = long_digits($urandom_range(11, 14));
      // leading zeros now and then
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) q.push_front(CH_ZERO);
      return q;
   endfunction

   function automatic byte_q_type pick_bytes();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 12) return decimal(64'($urandom_range(0, 99999)));
      if (sel < 16) return decimal({$urandom, $urandom});
      if (sel < 18) return decimal(64'h7FFF_FFFF_FFFF_FFFF + 64'($urandom_range(0, 1)));
      return long_digits($urandom_range(20, 24));
   endfunction

   function automatic logic [7:0] pick_sign();
      int sel;
      sel = $urandom_range(0, 9);
      return (sel == 0) ? CH_PLUS : (sel == 1) ? CH_MINUS : CH_NUL;
   endfunction

   // prefix, quote-space marker, status, separator, byte count, optional tail
   function automatic byte_q_type well_formed_line(logic [9:0] counted, logic [9:0] summed);
      byte_q_type q;
      logic [7:0] sign;
      int         sel;
      repeat ($urandom_range(0, 5)) q.push_back(text_char());
      if ($urandom_range(0, 3) == 0) begin
         q.push_back(CH_QUOTE);
         q.push_back(text_char());
      end
      q.push_back(CH_QUOTE);
      q.push_back(CH_SPACE);
      repeat ($urandom_range(0, 1)) q.push_back(blank_char());
      sign = pick_sign();
      if (sign != CH_NUL) q.push_back(sign);
      q = {q, pick_status(counted, summed)};
      sign = pick_sign();
      // a signed byte count may follow the status with no separator
      if (sign == CH_NUL || $urandom_range(0, 1)) begin
         repeat ($urandom_range(1, 2)) q.push_back(blank_char());
      end
      if (sign != CH_NUL) q.push_back(sign);
      q = {q, pick_bytes()};
      sel = $urandom_range(0, 5);
      if (sel == 0) begin
         q.push_back(CH_SPACE);
         repeat ($urandom_range(1, 3)) q.push_back(text_char());
      end else if (sel == 1) begin
         q.push_back(CH_NUL);
         repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range(0, 255)));
      end
      return q;
   endfunction

   function automatic byte_q_type broken_line();
      byte_q_type q;
      int    sel;
      sel = $urandom_range(0, 5);
      if (sel == 0) begin
         // raw noise over the whole byte range
         repeat ($urandom_range(1, 12)) q.push_back(8'($urandom_range(0, 255)));
         return q;
      end
      if (sel == 5) begin
         // quote never followed by a space
         q.push_back(CH_QUOTE);
         q = {q, decimal(64'($urandom_range(0, 999)))};
         q.push_back(CH_SPACE);
         return {q, decimal(64'($urandom_range(0, 999)))};
      end
      q.push_back(CH_QUOTE);
      q.push_back(CH_SPACE);
      case (sel)
         1: begin
            // byte count missing
            q = {q, decimal(64'($urandom_range(0, 999)))};
            repeat ($urandom_range(0, 2)) q.push_back(blank_char());
         end
         2: begin
            // sign with no digit after it
            q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            q.push_back(8'($urandom_range(65, 90)));
         end
         3: begin
            q = {q, decimal(64'($urandom_range(0, 999)))};
            q.push_back(CH_SPACE);
            q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            q.push_back(8'($urandom_range(97, 122)));
         end
         default: begin
            // zero byte before the status
            q.push_back(CH_NUL);
            q = {q, decimal(64'($urandom_range(0, 999)))};
         end
      endcase
      return q;
   endfunction

   // mostly well-formed lines, the rest broken or noise
   task automatic random_lines(int chars, int lines);
      int goal_chars;
      int goal_lines;
      goal_chars = reqs_taken + chars;
      goal_lines = sb.lines_seen + lines;
      while (reqs_taken < goal_chars || sb.lines_seen < goal_lines) begin
         if ($urandom_range(0, 4) != 0) send_line(well_formed_line(sb.counted, sb.summed));
         else send_line(broken_line());
      end
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------

   initial begin
      byte_q_type q;
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      burst_left = 0;
      calm = 0;
      reqs_taken = 0;
      code_settings = 1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset codes read back as 404 and 200
      csr_read(ADDR_COUNTED);
      csr_read(ADDR_SUMMED);

      // directed lines under the reset codes
      send_line(text("\" 404 5"));
      send_line(text("\" 200 7"));
      send_line(text("\" +200 -9223372036854775808"));
      // status and byte count past their limits saturate high and low
      send_line(text("\" 2147483648 99999999999999999999"));
      send_line(text("\" -2147483649 -99999999999999999999"));
      send_line(text("\" -2147483648 1"));
      // second number glued to the first by its sign
      send_line(text("\" 200-5"));
      // zero byte cuts the line inside the status, then after the byte count
      q = text("\" 200");
      q.push_back(CH_NUL);
      q.push_back(CH_SPACE);
      q.push_back(CH_ZERO + 8'd5);
      send_line(q);
      q = text("\" 200 5");
      q.push_back(CH_NUL);
      q.push_back(CH_NINE);
      send_line(q);
      send_line(text("\" 200 5 trailing"));
      send_line(text("\" \t\n 404\v\f\r 3"));
      send_line(text("a\"b\" 404 1"));
      send_line(text("\" +x 1"));
      send_line(text("\" 404"));
      send_line(text("x"));
      q = {};
      q.push_back(8'hFF);
      send_line(q);
      random_lines(55, 3);

      // counted code 0: lines that fail to parse count as errors
      apply_codes(10'd0, 10'd999);
      send_line(text("x"));
      send_line(text("\" 999 -42"));
      random_lines(55, 3);

      // summed code 0: failures add nothing, minus zero adds its bytes
      apply_codes(10'd999, 10'd0);
      send_line(text("\" +x"));
      send_line(text("\" -0 12"));
      random_lines(55, 3);

      // one code in both registers: only the error count moves
      apply_codes(10'd500, 10'd500);
      send_line(text("\" 500 3"));
      random_lines(55, 3);

      apply_codes(10'($urandom_range(0, 999)), 10'($urandom_range(0, 999)));
      random_lines(55, 3);

      settle();
      repeat (20) @(negedge clock);

      $display("covered %0d characters in %0d lines (%0d parsed)",
               reqs_taken, sb.lines_seen, sb.lines_parsed);
      $display("under %0d code settings, final error count %0d",
               code_settings, sb.err_lines);
      if (sb.failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches in total", sb.failures);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- access_log_status_byte_tally_unit.f -----
+incdir+sv
sv/alsbt_pkg.sv
sv/alsbt_front.sv
sv/alsbt_queue.sv
sv/alsbt_back.sv
sv/access_log_status_byte_tally_unit.sv
sv/alsbt_checker.sv
tb/sv/access_log_status_byte_tally_unit_test.sv
